>>> sv/pol_pkg.sv
package pol_pkg;

  localparam int CAPACITY  = 16;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 5;
  localparam int KIND_W    = 3;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 5;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W     = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_INSERT_AT  = 3'd4,
    KIND_REMOVE_AT  = 3'd5,
    KIND_READ_AT    = 3'd6,
    KIND_CLEAR      = 3'd7
  } kind_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic             en;
    logic             ins;   // 1: open a slot at idx, 0: close the slot at idx
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

>>> sv/pol_if.sv
interface pol_in_if import pol_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink (input valid, kind, position, value, output ready);
endinterface

interface pol_out_if import pol_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] removed_value;
  logic [CNT_OUT_W-1:0]    entry_count;
  logic [ST_W-1:0]         status;

  modport source (output valid, removed_value, entry_count, status, input ready);
  modport sink (input valid, removed_value, entry_count, status, output ready);
endinterface

>>> sv/pol_cell.sv
module pol_cell import pol_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] cell_idx,
  input  cell_ctrl_t       ctrl,
  input  logic [VAL_W-1:0] left_data,
  input  logic [VAL_W-1:0] right_data,
  output logic [VAL_W-1:0] data
);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (cell_idx == ctrl.idx) begin
        data_nxt = ctrl.value;
      end else if (cell_idx > ctrl.idx) begin
        data_nxt = left_data;
      end
    end else if (cell_idx >= ctrl.idx) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      data_r <= data_nxt;
    end
  end

  assign data = data_r;

endmodule

>>> sv/positional_ordered_list.sv
// Bounded ordered list of up to CAPACITY signed words, held in a row of cells.
// Every command (push/pop at either end, insert/remove/read at a 1-based
// position, clear) is applied at once: all cells compare their index with the
// target slot and shift left or right together, so a new beat is accepted
// every cycle while the result register can pass its beat on. Each command
// gives one result beat with the value removed or read, the new count and a
// status; a failed command leaves the list as it was.
module positional_ordered_list import pol_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pol_in_if.sink    in_ch,
  pol_out_if.source out_ch
);

  logic [VAL_W-1:0] cell_data [CAPACITY];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic [CNT_OUT_W-1:0]    out_count_r;
  status_t                 out_status_r;

  kind_t            kind;
  status_t          st;
  logic [VAL_W-1:0] res;
  logic             do_ins;
  logic             do_rem;
  logic             do_rd;
  logic [IDX_W-1:0] idx;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic             full;
  logic             empty;
  logic             fire;
  cell_ctrl_t       ctrl;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  assign kind  = kind_t'(in_ch.kind);
  assign pos_c = CMP_W'(in_ch.position);
  assign cnt_c = CMP_W'(count_r);
  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  always_comb begin
    st        = ST_OK;
    do_ins    = 1'b0;
    do_rem    = 1'b0;
    do_rd     = 1'b0;
    idx       = '0;
    count_nxt = count_r;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          do_ins    = 1'b1;
          idx       = (kind == KIND_PUSH_BACK) ? IDX_W'(count_r) : '0;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          do_rem    = 1'b1;
          do_rd     = 1'b1;
          idx       = (kind == KIND_POP_BACK) ? IDX_W'(count_r - CNT_W'(1)) : '0;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      KIND_INSERT_AT: begin
        if (full) begin
          st = ST_FULL;
        end else if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1)) begin
          st = ST_BADPOS;
        end else begin
          do_ins    = 1'b1;
          idx       = IDX_W'(pos_c - CMP_W'(1));
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_REMOVE_AT, KIND_READ_AT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (pos_c == '0 || pos_c > cnt_c) begin
          st = ST_BADPOS;
        end else begin
          do_rd = 1'b1;
          idx   = IDX_W'(pos_c - CMP_W'(1));
          if (kind == KIND_REMOVE_AT) begin
            do_rem    = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    res = do_rd ? cell_data[idx] : '0;
  end

  assign ctrl.en    = fire && (do_ins || do_rem);
  assign ctrl.ins   = do_ins;
  assign ctrl.idx   = idx;
  assign ctrl.value = in_ch.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_data;
    logic [VAL_W-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = in_ch.value;
    end else begin : g_left
      assign left_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_right
      assign right_data = cell_data[i+1];
    end
    pol_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .ctrl       (ctrl),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_value_r  <= res;
      out_count_r  <= CNT_OUT_W'(count_nxt);
      out_status_r <= st;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.removed_value = out_value_r;
  assign out_ch.entry_count   = out_count_r;
  assign out_ch.status        = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && out_count_r == CNT_OUT_W'(count_r))
    else $error("result beat missing or count mismatch");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FULL |-> out_count_r == CNT_OUT_W'(CAPACITY))
    else $error("full status with list not full");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_value_r == '0)
    else $error("non-zero value on failed command");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_EMPTY |-> out_count_r == '0)
    else $error("empty status with entries present");

endmodule

>>> tb/positional_ordered_list_tb.sv
`timescale 1ns / 100ps

module positional_ordered_list_tb;
  import pol_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS   = 110;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [CNT_OUT_W-1:0]    count;
    status_t                 status;
  } list_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pol_in_if  in_ch ();
  pol_out_if out_ch ();

  positional_ordered_list u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the list contents
  logic signed [VAL_W-1:0] shadow_list [CAPACITY];
  int                      shadow_count = 0;
  list_result_t            pending_results [$];

  int error_count    = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void open_slot(input int slot, input logic signed [VAL_W-1:0] v);
    int i;
    for (i = shadow_count; i > slot; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[slot] = v;
    shadow_count++;
  endfunction

  function automatic logic signed [VAL_W-1:0] close_slot(input int slot);
    logic signed [VAL_W-1:0] v;
    int i;
    v = shadow_list[slot];
    for (i = slot; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
    shadow_count--;
    return v;
  endfunction

  function automatic list_result_t apply_command(input kind_t k, input logic [POS_W-1:0] p,
                                                 input logic signed [VAL_W-1:0] v);
    list_result_t r;
    int pos;
    pos      = int'(p);
    r.value  = '0;
    r.status = ST_OK;
    case (k)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (shadow_count >= CAPACITY) r.status = ST_FULL;
        else open_slot((k == KIND_PUSH_FRONT) ? 0 : shadow_count, v);
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else r.value = close_slot((k == KIND_POP_FRONT) ? 0 : shadow_count - 1);
      end
      KIND_INSERT_AT: begin
        // full is flagged ahead of a bad position
        if (shadow_count >= CAPACITY) r.status = ST_FULL;
        else if (pos < 1 || pos > shadow_count + 1) r.status = ST_BADPOS;
        else open_slot(pos - 1, v);
      end
      KIND_REMOVE_AT, KIND_READ_AT: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else if (pos < 1 || pos > shadow_count) r.status = ST_BADPOS;
        else if (k == KIND_REMOVE_AT) r.value = close_slot(pos - 1);
        else r.value = shadow_list[pos-1];
      end
      default: shadow_count = 0;
    endcase
    r.count = CNT_OUT_W'(shadow_count);
    return r;
  endfunction

  task automatic send_command(input kind_t k, input logic [POS_W-1:0] p,
                              input logic signed [VAL_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid    = 1'b1;
    in_ch.kind     = k;
    in_ch.position = p;
    in_ch.value    = v;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(apply_command(k, p, v));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual value %0d count %0d status %0d",
                 $time, out_ch.removed_value, out_ch.entry_count, out_ch.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("removed_value", want.value, out_ch.removed_value);
        check_field("entry_count", want.count, out_ch.entry_count);
        check_field("status", want.status, out_ch.status);
      end
    end
  end

  task automatic test_empty_list();
    send_command(KIND_POP_FRONT, 5'd0, 32'sd0);
    send_command(KIND_POP_BACK, 5'd0, 32'sd0);
    send_command(KIND_REMOVE_AT, 5'd1, 32'sd0);
    send_command(KIND_READ_AT, 5'd1, 32'sd0);
    // empty is reported ahead of a bad position
    send_command(KIND_READ_AT, 5'd0, 32'sd0);
    send_command(KIND_INSERT_AT, 5'd0, 32'sd5);
    send_command(KIND_INSERT_AT, 5'd2, 32'sd5);
    send_command(KIND_INSERT_AT, 5'd1, 32'sh8000_0000);
  endtask

  task automatic test_fill_to_capacity();
    int i;
    for (i = 1; i < CAPACITY; i++) begin
      case (i % 3)
        0: send_command(KIND_PUSH_FRONT, 5'd0, 32'sh7FFF_FFFF);
        1: send_command(KIND_PUSH_BACK, 5'd31, -32'sd1);
        default: send_command(KIND_INSERT_AT, POS_W'(shadow_count / 2 + 1), VAL_W'(i));
      endcase
    end
    send_command(KIND_PUSH_FRONT, 5'd0, 32'sd1);
    send_command(KIND_PUSH_BACK, 5'd0, 32'sd2);
    send_command(KIND_INSERT_AT, 5'd0, 32'sd3);
  endtask

  task automatic test_position_limits();
    send_command(KIND_READ_AT, 5'd16, 32'sd0);
    send_command(KIND_READ_AT, 5'd17, 32'sd0);
    send_command(KIND_REMOVE_AT, 5'd31, 32'sd0);
    send_command(KIND_REMOVE_AT, 5'd16, 32'sd0);
    send_command(KIND_INSERT_AT, 5'd16, 32'sh5A5A_A5A5);
    send_command(KIND_POP_FRONT, 5'd0, 32'sd0);
    send_command(KIND_POP_BACK, 5'd0, 32'sd0);
    send_command(KIND_CLEAR, 5'd0, 32'sd0);
    send_command(KIND_CLEAR, 5'd31, -32'sd1);
  endtask

  // fill/drain sweeps with random content, plus some noise
  task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
    int                      i;
    int                      grow_pct;
    int                      top;
    bit                      filling;
    kind_t                   k;
    logic [POS_W-1:0]        p;
    logic signed [VAL_W-1:0] v;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    filling        = (shadow_count < CAPACITY / 2);
    for (i = 0; i < n_items; i++) begin
      if (shadow_count == CAPACITY) filling = 1'b0;
      if (shadow_count == 0) filling = 1'b1;
      grow_pct = filling ? 80 : 20;
      if ($urandom_range(99) < 8) begin
        k = kind_t'($urandom_range(7));
      end else if ($urandom_range(99) < 15) begin
        k = KIND_READ_AT;
      end else if ($urandom_range(99) < grow_pct) begin
        case ($urandom_range(2))
          0: k = KIND_PUSH_FRONT;
          1: k = KIND_PUSH_BACK;
          default: k = KIND_INSERT_AT;
        endcase
      end else begin
        case ($urandom_range(2))
          0: k = KIND_POP_FRONT;
          1: k = KIND_POP_BACK;
          default: k = KIND_REMOVE_AT;
        endcase
      end
      if ($urandom_range(99) < 85) begin
        top = (k == KIND_INSERT_AT) ? shadow_count + 1 : shadow_count;
        if (top < 1) top = 1;
        p = POS_W'($urandom_range(top, 1));
      end else begin
        p = POS_W'($urandom_range(31));
      end
      v = $urandom;
      send_command(k, p, v);
    end
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.kind     = KIND_CLEAR;
    in_ch.position = '0;
    in_ch.value    = '0;
    out_ch.ready   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_fill_to_capacity();
    test_position_limits();
    wait_for_results();

    test_random_traffic(PHASE_ITEMS, 0, 0);
    wait_for_results();
    test_random_traffic(PHASE_ITEMS, 87, 0);
    test_random_traffic(PHASE_ITEMS, 0, 87);
    wait_for_results();
    test_random_traffic(PHASE_ITEMS, 36, 36);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
